/* sv/pfc_pkg.sv */
`timescale 1ns / 1ps
// pfc_pkg: shared types and constants for the prime factor count block
// no dependencies

package pfc_pkg;

  // width of the result field and its saturation value
  localparam int unsigned COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // width of the result tdata, padded to whole bytes
  localparam int unsigned M_TDATA_W = ((COUNT_W + 7) / 8) * 8;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage

/* sv/prime_factor_count.sv */
`timescale 1ns / 1ps
// prime_factor_count: counts prime factors of |value| with multiplicity
// depends on pfc_pkg and pfc_divider

// Takes one signed value per item and returns the number of prime factors of
// its magnitude, counted with multiplicity and saturated at 31; zero gives 0
// and a magnitude of one gives 1. The low VALUE_WIDTH bits of s_tdata are the
// operand, sign-extended from bit VALUE_WIDTH-1. Factors of two are stripped
// one per cycle, then odd trial divisors from 3 upward go through a single
// shared bit-serial divider. Each division yields both the quotient for the
// stop test (divisor above quotient) and the remainder for the factor test.
// The time an item takes grows with its trailing zeros, its odd factors and
// the square root of its odd part. The divider sets the rate; one item is in
// work at a time, and a new item can be taken while the previous result
// still waits on the output.

module prime_factor_count #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [VALUE_WIDTH-1:0] value (two's complement), upper bits ignored
  input  logic [((VALUE_WIDTH > 32) ? (((VALUE_WIDTH + 7) / 8) * 8) : 32)-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [4:0] factor_count, [7:5] zero
  output logic [pfc_pkg::M_TDATA_W-1:0] m_tdata
);

  import pfc_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  state_t           state;
  state_t           state_next;
  logic [W-1:0]     n;
  logic [W-1:0]     n_next;
  logic [W-1:0]     d;
  logic [W-1:0]     d_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] result;
  logic             m_tvalid_next;
  logic             load_out;
  logic             div_start;
  logic             div_done;
  logic [W-1:0]     div_q;
  logic [W-1:0]     div_r;
  logic [W-1:0]     raw;
  logic [W-1:0]     mag;
  logic             out_free;
  logic             in_take;

  // exact magnitude of the operand
  assign raw = s_tdata[W-1:0];
  assign mag = raw[W-1] ? (~raw + 1'b1) : raw;

  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign in_take   = s_tvalid && s_tready;

  // shared trial divider
  pfc_divider #(
    .WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (mag == '0 || mag == W'(1)) state_next = ST_FINISH;
          else state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (n[0]) state_next = ST_DIV;
      end
      ST_DIV: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (d > div_q) state_next = ST_FINISH;
          else state_next = ST_DIV;
        end
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath updates and sequencer outputs
  always_comb begin
    n_next     = n;
    d_next     = d;
    count_next = count;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          n_next     = mag;
          count_next = (mag == W'(1)) ? COUNT_W'(1) : '0;
        end
      end
      ST_STRIP: begin
        if (!n[0]) begin
          n_next     = n >> 1;
          count_next = count_inc;
        end else begin
          d_next = W'(3);
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (d > div_q) begin
            // leftover above one is a single prime
            if (n > W'(1)) count_next = count_inc;
          end else if (div_r == '0) begin
            n_next     = div_q;
            count_next = count_inc;
          end else begin
            d_next = d + W'(2);
          end
        end
      end
      ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
        n_next = n;
      end
    endcase
  end

  // output register
  assign m_tvalid_next = (m_tvalid && !m_tready) || load_out;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n     <= n_next;
    d     <= d_next;
    count <= count_next;
    if (load_out) result <= count;
  end

  assign m_tdata = {{(M_TDATA_W - COUNT_W){1'b0}}, result};

endmodule

/* sv/pfc_divider.sv */
`timescale 1ns / 1ps
// pfc_divider: shared restoring divider, one quotient bit per cycle
// standalone; used by prime_factor_count

module pfc_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(WIDTH);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // one trial subtract per cycle
  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr};

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for prime_factor_count, one operand in, one count out
// depends on pfc_pkg and the prime_factor_count rtl with its divider

module tb;

  import pfc_pkg::*;

  localparam int unsigned VW = 32;

  // scoreboard: predicts the count for each accepted operand, checks results in order
  class factor_scoreboard;
    logic [COUNT_W-1:0] expected_counts[$];
    logic [VW-1:0]      pending_values[$];
    int unsigned        errors = 0;

    // number of prime factors of |raw| with multiplicity, saturated
    function logic [COUNT_W-1:0] omega_of(logic [VW-1:0] raw);
      logic [VW-1:0]     mag;
      longint unsigned   n;
      longint unsigned   d;
      int unsigned       cnt;
      mag = raw[VW-1] ? (~raw + 1'b1) : raw;
      n   = 64'(mag);
      cnt = 0;
      if (n == 1) begin
        cnt = 1;
      end else if (n != 0) begin
        while ((n & 1) == 0) begin
          cnt++;
          n = n >> 1;
        end
        d = 3;
        while (d <= n / d) begin
          while (n % d == 0) begin
            cnt++;
            n = n / d;
          end
          d += 2;
        end
        if (n > 1) cnt++;
      end
      if (cnt > COUNT_MAX) cnt = 32'(COUNT_MAX);
      return COUNT_W'(cnt);
    endfunction

    function void note_value(logic [VW-1:0] value);
      expected_counts = {expected_counts, omega_of(value)};
      pending_values  = {pending_values, value};
    endfunction

    function void check_count(logic [COUNT_W-1:0] actual);
      logic [COUNT_W-1:0] want;
      logic [VW-1:0]      value;
      if (expected_counts.size() == 0) begin
        $error("factor_count: result with no item pending, actual %0d", actual);
        errors++;
        return;
      end
      want  = expected_counts.pop_front();
      value = pending_values.pop_front();
      if (actual !== want) begin
        $error("factor_count for value %0d: expected %0d, actual %0d",
               $signed(value), want, actual);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [VW-1:0]        s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  logic [6:0]           phase_cnt = '0;
  logic [1:0]           ready_mode = '0;

  factor_scoreboard sb = new();

  prime_factor_count #(.VALUE_WIDTH(VW)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // receiver: stall mode is picked anew at random whenever phase_cnt wraps to zero
  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1'b1;
    if (phase_cnt == '0) ready_mode <= 2'($urandom_range(0, 3));
    case (ready_mode)
      2'd0: begin
        m_tready <= 1'b1;
      end
      2'd1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        m_tready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        m_tready <= phase_cnt[4];
      end
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_count(m_tdata[COUNT_W-1:0]);
  end

  // two's complement of a magnitude, sign chosen at random
  function automatic logic [VW-1:0] with_sign(longint unsigned m);
    if ($urandom_range(0, 1)) return VW'(64'd0 - m);
    return VW'(m);
  endfunction

  // product of small primes below 2^31, small primes favored
  function automatic longint unsigned smooth_magnitude();
    int unsigned     primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                    43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
    longint unsigned m;
    int unsigned     p;
    int unsigned     steps;
    m     = 1;
    steps = $urandom_range(1, 31);
    repeat (steps) begin
      p = primes[$urandom_range(0, $urandom_range(0, 24))];
      if (m * p < 64'h8000_0000) m = m * p;
    end
    return m;
  endfunction

  // random operand: mostly small or smooth so trial division stays short
  function automatic logic [VW-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return with_sign(64'($urandom_range(0, 4095)));
    if (pick < 85) return with_sign(smooth_magnitude());
    if (pick < 95) return with_sign(64'($urandom_range(0, 262143)));
    return with_sign(longint'($urandom_range(1, 4095)) << $urandom_range(0, 19));
  endfunction

  task automatic send_value(input logic [VW-1:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_value(v);
  endtask

  task automatic pause_cycles(input int unsigned n);
    if (n != 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= VW'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  localparam int unsigned N_RANDOM = 100;

  initial begin
    logic [VW-1:0] directed[$];
    int unsigned   sent;
    int unsigned   burst;
    int unsigned   gap;
    bit            drained_mid;

    // zero, magnitude one, most negative, smooth values at both ends, prime squares
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 32'd3, 32'd4,
                 32'h8000_0000, 32'h4000_0000, 32'h7FFF_FFFE, 32'h8000_0002,
                 32'd9, 32'd25, 32'd49, 32'd15, 32'd8633, 32'd65537, 32'hFFFE_FFFF,
                 32'd1162261467, 32'hBAB9_8B25, 32'h5555_5555, 32'hAAAA_AAAB,
                 32'd223092870, 32'h6000_0000, 32'd1021};

    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed items back to back
    foreach (directed[i]) send_value(directed[i]);
    drain_results();

    // random items in bursts
    sent        = 0;
    drained_mid = 1'b0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 12);
      for (int unsigned k = 0; k < burst && sent < N_RANDOM; k++) begin
        send_value(random_value());
        sent++;
      end
      if (!drained_mid && sent >= N_RANDOM / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end else begin
        case ($urandom_range(0, 3))
          0:       gap = 0;
          1:       gap = $urandom_range(1, 4);
          2:       gap = $urandom_range(5, 60);
          default: gap = $urandom_range(60, 1500);
        endcase
        pause_cycles(gap);
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #(20_000_000);
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* prime_factor_count.f */
sv/pfc_pkg.sv
sv/pfc_divider.sv
sv/prime_factor_count.sv
test/tb.sv
